// ===== src/prcs_pkg.sv =====
`timescale 1ns / 1ps

package prcs_pkg;

  localparam int unsigned PAGE_BYTES     = 1024;
  localparam int unsigned MAX_READ_WORDS = 8192;
  localparam int unsigned RESULT_LIMIT   = 34;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned AddrW   = 24;
  localparam int unsigned WordsW  = 14;
  localparam int unsigned BytesW  = 11;
  localparam int unsigned CodeW   = 11;
  localparam int unsigned EntryW  = 6;
  localparam int unsigned OffW    = 5;
  localparam int unsigned CmdW    = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 8;

  localparam int unsigned PageBits = $clog2(PAGE_BYTES);
  localparam int unsigned RemW     = $clog2(MAX_READ_WORDS * 4) + 1;
  localparam int unsigned CntW     = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned QPtrW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCntW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] READ_CMD = 8'hEB;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAGE_CROSS = 4'd0,
    REG_PROG_BASE  = 4'd1,
    REG_READ_OFF   = 4'd2,
    REG_READ1_OFF  = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic            page_cross;
    logic [OffW-1:0] prog_base;
    logic [OffW-1:0] read_off;
    logic [OffW-1:0] read1_off;
  } cfg_t;

  // One burst descriptor passed from the splitter to the formatter.
  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [BytesW-1:0] bytes;
    logic              last;
  } burst_t;

endpackage

// ===== src/prcs_front.sv =====
`timescale 1ns / 1ps

module prcs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic [prcs_pkg::AddrW-1:0]     start_address_i,
  input  logic [prcs_pkg::WordsW-1:0]    length_words_i,
  input  logic                           page_cross_i,
  input  logic                           full_i,
  output logic                           push_o,
  output prcs_pkg::burst_t               burst_o,
  output logic                           busy_o
);

  logic                              active_q, active_d;
  logic [prcs_pkg::AddrW-1:0]        addr_q, addr_d;
  logic [prcs_pkg::RemW-1:0]         rem_q, rem_d;
  logic [prcs_pkg::BytesW-1:0]       burst_q, burst_d;
  logic [prcs_pkg::CntW-1:0]         cnt_q, cnt_d;

  logic [prcs_pkg::WordsW-1:0]       words_sat;
  logic [prcs_pkg::RemW-1:0]         rem_init;
  logic [prcs_pkg::BytesW-1:0]       first_page;
  logic [prcs_pkg::BytesW-1:0]       first_burst;
  logic [prcs_pkg::RemW-1:0]         rem_next;
  logic [prcs_pkg::CntW-1:0]         cnt_next;
  logic                              last;
  logic                              accept;

  always_comb begin
    words_sat = (length_words_i > prcs_pkg::WordsW'(prcs_pkg::MAX_READ_WORDS)) ?
                prcs_pkg::WordsW'(prcs_pkg::MAX_READ_WORDS) : length_words_i;
    rem_init  = prcs_pkg::RemW'(words_sat) << 2;
    // Split at the end of the start page unless crossing is allowed.
    first_page = page_cross_i ? prcs_pkg::BytesW'(prcs_pkg::PAGE_BYTES) :
                 prcs_pkg::BytesW'(prcs_pkg::PAGE_BYTES) -
                 prcs_pkg::BytesW'(start_address_i[prcs_pkg::PageBits-1:0]);
    first_burst = (prcs_pkg::RemW'(first_page) > rem_init) ?
                  prcs_pkg::BytesW'(rem_init) : first_page;

    push_o   = active_q && !full_i;
    rem_next = rem_q - prcs_pkg::RemW'(burst_q);
    cnt_next = cnt_q + prcs_pkg::CntW'(1);
    last     = (rem_next == '0) || (cnt_next == prcs_pkg::CntW'(prcs_pkg::RESULT_LIMIT));

    burst_o.addr  = addr_q;
    burst_o.bytes = burst_q;
    burst_o.last  = last;

    accept = start && !active_q;

    active_d = active_q;
    addr_d   = addr_q;
    rem_d    = rem_q;
    burst_d  = burst_q;
    cnt_d    = cnt_q;
    if (accept && (length_words_i != '0)) begin
      active_d = 1'b1;
      addr_d   = start_address_i;
      rem_d    = rem_init;
      burst_d  = first_burst;
      cnt_d    = '0;
    end else if (push_o) begin
      active_d = !last;
      addr_d   = addr_q + prcs_pkg::AddrW'(burst_q);
      rem_d    = rem_next;
      cnt_d    = cnt_next;
      burst_d  = (rem_next > prcs_pkg::RemW'(prcs_pkg::PAGE_BYTES)) ?
                 prcs_pkg::BytesW'(prcs_pkg::PAGE_BYTES) : prcs_pkg::BytesW'(rem_next);
    end
  end

  assign busy_o = active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    rem_q   <= rem_d;
    burst_q <= burst_d;
  end

endmodule

// ===== src/prcs_queue.sv =====
`timescale 1ns / 1ps

module prcs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  prcs_pkg::burst_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output prcs_pkg::burst_t data_o
);

  prcs_pkg::burst_t                slot_q [prcs_pkg::QUEUE_DEPTH];
  logic [prcs_pkg::QPtrW-1:0]      wr_q, wr_d;
  logic [prcs_pkg::QPtrW-1:0]      rd_q, rd_d;
  logic [prcs_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == prcs_pkg::QCntW'(prcs_pkg::QUEUE_DEPTH));
    empty_o = (cnt_q == '0);
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    data_o  = slot_q[rd_q];
    wr_d    = do_push ? wr_q + prcs_pkg::QPtrW'(1) : wr_q;
    rd_d    = do_pop ? rd_q + prcs_pkg::QPtrW'(1) : rd_q;
    cnt_d   = cnt_q + prcs_pkg::QCntW'(do_push) - prcs_pkg::QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/prcs_back.sv =====
`timescale 1ns / 1ps

module prcs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prcs_pkg::cfg_t                cfg_i,
  input  logic                          empty_i,
  input  prcs_pkg::burst_t              burst_i,
  output logic                          pop_o,
  output logic                          strobe_o,
  output logic [prcs_pkg::CodeW-1:0]    count_code_o,
  output logic [prcs_pkg::CmdW-1:0]     command_word_o,
  output logic [prcs_pkg::EntryW-1:0]   program_entry_o,
  output logic [prcs_pkg::BytesW-1:0]   burst_bytes_o,
  output logic                          last_burst_o
);

  logic                          strobe_q;
  logic [prcs_pkg::CodeW-1:0]    code_q, code_d;
  logic [prcs_pkg::CmdW-1:0]     cmd_q, cmd_d;
  logic [prcs_pkg::EntryW-1:0]   entry_q, entry_d;
  logic [prcs_pkg::BytesW-1:0]   bytes_q;
  logic                          last_q;
  logic                          one;
  logic [prcs_pkg::OffW-1:0]     off;

  always_comb begin
    pop_o   = !empty_i;
    one     = (burst_i.bytes < prcs_pkg::BytesW'(2));
    off     = one ? cfg_i.read1_off : cfg_i.read_off;
    // Nibble count minus four; single byte uses its own routine and code zero.
    code_d  = one ? '0 : prcs_pkg::CodeW'({burst_i.bytes, 1'b0} - 12'd4);
    cmd_d   = {prcs_pkg::READ_CMD, burst_i.addr};
    entry_d = prcs_pkg::EntryW'(cfg_i.prog_base) + prcs_pkg::EntryW'(off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      code_q  <= code_d;
      cmd_q   <= cmd_d;
      entry_q <= entry_d;
      bytes_q <= burst_i.bytes;
      last_q  <= burst_i.last;
    end
  end

  assign strobe_o        = strobe_q;
  assign count_code_o    = code_q;
  assign command_word_o  = cmd_q;
  assign program_entry_o = entry_q;
  assign burst_bytes_o   = bytes_q;
  assign last_burst_o    = last_q;

endmodule

// ===== src/psram_read_command_splitter.sv =====
`timescale 1ns / 1ps

// Read command splitter for a quad-SPI PSRAM.
//
// Request channel: drive start with start_address_i and length_words_i; the
// request is taken at a rising edge where start is high and busy is low.
// A zero length is taken and produces no burst.
// Burst channel: each burst appears for exactly one cycle with strobe_o high;
// there is no backpressure, the receiver must take every beat.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, unknown indexes are dropped. Write only when idle.
//
// Timing: the first burst beat passes the front, queue and output registers
// after the request is taken, then one beat per cycle. Busy stays high
// until the splitter loop, issuing one burst descriptor per cycle while the
// queue is not full, has pushed the last burst of the request.
// Reset clears the configuration to zero and empties the burst queue.
module psram_read_command_splitter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [prcs_pkg::AddrW-1:0]          start_address_i,
  input  logic [prcs_pkg::WordsW-1:0]         length_words_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [prcs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [prcs_pkg::CfgDatW-1:0]        cfg_data_i,
  output logic                                strobe_o,
  output logic [prcs_pkg::CodeW-1:0]          count_code_o,
  output logic [prcs_pkg::CmdW-1:0]           command_word_o,
  output logic [prcs_pkg::EntryW-1:0]         program_entry_o,
  output logic [prcs_pkg::BytesW-1:0]         burst_bytes_o,
  output logic                                last_burst_o
);

  prcs_pkg::cfg_t    cfg_q, cfg_d;
  prcs_pkg::burst_t  front_burst, queue_burst;
  logic              push, pop, full, empty;

  // Configuration registers: always ready, write on valid.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (prcs_pkg::cfg_reg_e'(cfg_index_i))
        prcs_pkg::REG_PAGE_CROSS: cfg_d.page_cross = cfg_data_i[0];
        prcs_pkg::REG_PROG_BASE:  cfg_d.prog_base  = cfg_data_i[prcs_pkg::OffW-1:0];
        prcs_pkg::REG_READ_OFF:   cfg_d.read_off   = cfg_data_i[prcs_pkg::OffW-1:0];
        prcs_pkg::REG_READ1_OFF:  cfg_d.read1_off  = cfg_data_i[prcs_pkg::OffW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: take the request and cut it into bursts of at most one page each.
  prcs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .start_address_i (start_address_i),
    .length_words_i  (length_words_i),
    .page_cross_i    (cfg_q.page_cross),
    .full_i          (full),
    .push_o          (push),
    .burst_o         (front_burst),
    .busy_o          (busy)
  );

  // Short queue decoupling the splitter from the formatter.
  prcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_burst),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (queue_burst)
  );

  // Back: build count code, command word and sequencer entry, one beat a cycle.
  prcs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .burst_i         (queue_burst),
    .pop_o           (pop),
    .strobe_o        (strobe_o),
    .count_code_o    (count_code_o),
    .command_word_o  (command_word_o),
    .program_entry_o (program_entry_o),
    .burst_bytes_o   (burst_bytes_o),
    .last_burst_o    (last_burst_o)
  );

endmodule
